>>> design/psc_pkg.sv
// Package for the priority tick scheduler: widths, codes, payload and control types.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

    localparam int NUM_PROCS_DEF = 4;
    localparam int PROC_W        = 3;
    localparam int PRIO_W        = 8;
    localparam int TICK_W        = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 4;

    // register index taken from paddr[3]
    localparam logic REG_PRIORITY_WORDS = 1'b0;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_BLOCK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [PROC_W-1:0] proc_index;
        logic              blocked;
    } psc_req_t;

    typedef struct packed {
        logic [PROC_W-1:0] current_proc;
        logic [PRIO_W-1:0] current_ticks;
        logic              reloaded;
        logic [TICK_W-1:0] tick_count;
    } psc_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_FLAG
    } psc_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic flag_wr;
        logic sel_cur;
    } psc_cmd_t;

    typedef struct packed {
        logic scan_last;
    } psc_sts_t;

endpackage
`default_nettype wire

>>> design/psc_ctrl.sv
// Controller state machine for the priority tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
module psc_ctrl
    import psc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     req_type,
    input  wire psc_sts_t sts,
    output psc_cmd_t      cmd,
    output logic          busy
);

    psc_state_t state_reg;
    psc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_TICK) ? ST_SCAN : ST_FLAG;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            ST_FLAG:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:   cmd.step = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            ST_FLAG:
            begin
                cmd.flag_wr = 1'b1;
                cmd.sel_cur = 1'b1;
            end
            default:   cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> design/psc_dp.sv
// Datapath for the priority tick scheduler: process table, scan unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module psc_dp
    import psc_pkg::*;
#(
    parameter int NUM_PROCS = NUM_PROCS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire psc_req_t                   req,
    input  wire logic [NUM_PROCS*PRIO_W-1:0] prio_words,
    input  wire psc_cmd_t                   cmd,
    output psc_sts_t                        sts,
    output psc_rsp_t                        rsp,
    output logic                            done
);

    localparam int IDXW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

    psc_req_t                req_reg;
    logic [IDXW-1:0]         idx_reg,      idx_next;
    logic [IDXW-1:0]         best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]       best_reg,     best_next;
    logic [IDXW-1:0]         cur_reg,      cur_next;
    logic [TICK_W-1:0]       gticks_reg,   gticks_next;
    logic [PRIO_W-1:0]       ticks_reg [NUM_PROCS];
    logic [PRIO_W-1:0]       ticks_next [NUM_PROCS];
    logic [NUM_PROCS-1:0]    blk_reg,      blk_next;
    psc_rsp_t                rsp_reg,      rsp_next;
    logic                    done_reg,     done_next;

    logic [IDXW-1:0]         rd_addr;
    logic [PRIO_W-1:0]       rd_ticks;
    logic                    rd_blk;
    logic [PRIO_W-1:0]       step_val;
    logic                    proc_ok;

    assign rd_addr  = cmd.sel_cur ? cur_reg : idx_reg;
    assign rd_ticks = ticks_reg[rd_addr];
    assign rd_blk   = blk_reg[rd_addr];
    assign proc_ok  = ({1'b0, req_reg.proc_index} < (PROC_W + 1)'(NUM_PROCS));

    always_comb
    begin
        step_val = rd_ticks;
        if ((idx_reg == cur_reg) && (rd_ticks != '0))
        begin
            step_val = rd_ticks - PRIO_W'(1);
        end
    end

    assign sts.scan_last = (idx_reg == IDXW'(NUM_PROCS - 1));

    always_comb
    begin
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        cur_next      = cur_reg;
        gticks_next   = gticks_reg;
        ticks_next    = ticks_reg;
        blk_next      = blk_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;

        if (cmd.load)
        begin
            idx_next      = '0;
            best_next     = '0;
            best_idx_next = '0;
            if (req.req_type == REQ_TICK)
            begin
                gticks_next = gticks_reg + TICK_W'(1);
            end
        end

        if (cmd.step)
        begin
            ticks_next[idx_reg] = step_val;
            if (!rd_blk && (step_val > best_reg))
            begin
                best_next     = step_val;
                best_idx_next = idx_reg;
            end
            idx_next = idx_reg + IDXW'(1);
        end

        if (cmd.finish)
        begin
            rsp_next.tick_count = gticks_reg;
            done_next           = 1'b1;
            if (best_reg == '0)
            begin
                for (int i = 0; i < NUM_PROCS; i++)
                begin
                    ticks_next[i] = prio_words[i*PRIO_W +: PRIO_W];
                end
                rsp_next.current_proc  = PROC_W'(cur_reg);
                rsp_next.current_ticks = prio_words[cur_reg*PRIO_W +: PRIO_W];
                rsp_next.reloaded      = 1'b1;
            end
            else
            begin
                cur_next               = best_idx_reg;
                rsp_next.current_proc  = PROC_W'(best_idx_reg);
                rsp_next.current_ticks = best_reg;
                rsp_next.reloaded      = 1'b0;
            end
        end

        if (cmd.flag_wr)
        begin
            if (proc_ok)
            begin
                blk_next[req_reg.proc_index[IDXW-1:0]] = req_reg.blocked;
            end
            rsp_next.current_proc  = PROC_W'(cur_reg);
            rsp_next.current_ticks = rd_ticks;
            rsp_next.reloaded      = 1'b0;
            rsp_next.tick_count    = gticks_reg;
            done_next              = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            gticks_reg <= '0;
            blk_reg    <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            cur_reg    <= cur_next;
            gticks_reg <= gticks_next;
            blk_reg    <= blk_next;
            done_reg   <= done_next;
            ticks_reg  <= ticks_next;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

>>> design/priority_tick_scheduler_core.sv
// Top level of the priority tick scheduler: APB register, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Request channel: drive req and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been produced.
//   Result channel: rsp is valid for exactly one cycle while done is high.
//   The receiver cannot stall; every transaction yields exactly one result.
//   A tick request walks the process table one entry per cycle through the
//   single scan unit, then picks the winner or reloads the table in the
//   finish state; done is registered and rises once that state ends. A
//   blocked-flag write raises done, registered, once the flag state ends. A
//   new request is taken at the edge that ends the done cycle.
//   Config: APB write of priority_words (64 bits) at byte address 0 (any address
//   with paddr[3] low); write only while busy is low and no result is pending.
//   Reset: process ticks and blocked flags clear, current process is 0, the
//   tick counter and priority_words clear.
module priority_tick_scheduler_core
    import psc_pkg::*;
#(
    parameter int NUM_PROCS = NUM_PROCS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire psc_req_t              req,
    output logic                       done,
    output psc_rsp_t                   rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [CFG_DATA_W-1:0] prio_reg;
    logic [CFG_DATA_W-1:0] prio_next;
    logic                  cfg_wr;
    psc_cmd_t              cmd;
    psc_sts_t              sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prio_next = prio_reg;
        if (cfg_wr && (paddr[3] == REG_PRIORITY_WORDS))
        begin
            prio_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg <= '0;
        end
        else
        begin
            prio_reg <= prio_next;
        end
    end

    assign prdata = (paddr[3] == REG_PRIORITY_WORDS) ? prio_reg : '0;

    psc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    psc_dp #(
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .prio_words (prio_reg[NUM_PROCS*PRIO_W-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp),
        .done       (done)
    );

endmodule
`default_nettype wire
